// ----- src/aip_pkg.sv -----
// Shared widths and limits for the ASCII integer parser.
// No dependencies; imported by the parser, its checker and its testbench.
package aip_pkg;

  localparam int VALUE_W   = 32;     // accumulator width, wraps modulo 2^VALUE_W
  localparam int MAX_LEN   = 4095;   // offset saturation point
  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int CH_W      = 8;
  localparam int BASE_W    = 6;
  localparam int DIGIT_W   = 6;
  localparam int OUT_VAL_W = 32;
  localparam int OFFSET_W  = 12;
  localparam int OUT_RAW_W = OUT_VAL_W + OFFSET_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

  typedef logic [CH_W-1:0]        char_t;
  typedef logic [BASE_W-1:0]      base_t;
  typedef logic [VALUE_W-1:0]     acc_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

endpackage

// ----- src/ascii_integer_parser.sv -----
// Streaming ASCII-to-integer converter, top level.
// Depends on aip_pkg for widths, limits and types.
//
// An accepted input beat goes into the input register; the parse step then
// writes its result into the result register. Throughput: one character per
// cycle while no result waits on m_axis_tready; the single parse step (one narrow
// multiply-add of accumulator by base plus the phase update) sets that figure.
// Reset (rst, synchronous, active high): phase idle, accumulator and offset
// cleared, base register back to ten, both pipeline registers emptied.
module ascii_integer_parser (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: conversion base, 0 = detect from prefix
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  aip_pkg::base_t             cfg_data,
  // Character stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  aip_pkg::char_t             s_axis_tdata,   // [7:0] ch
  input  logic                       s_axis_tuser,   // [0] start_req
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output aip_pkg::out_tdata_t        m_axis_tdata    // [31:0] value, [43:32] end_offset, rest 0
);
  import aip_pkg::*;

  // Phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_BLANK  = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_PREFIX = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  // Characters of interest
  localparam char_t C_SPACE = 8'h20;
  localparam char_t C_TAB   = 8'h09;
  localparam char_t C_CR    = 8'h0D;
  localparam char_t C_PLUS  = 8'h2B;
  localparam char_t C_MINUS = 8'h2D;
  localparam char_t C_ZERO  = 8'h30;
  localparam char_t C_NINE  = 8'h39;
  localparam char_t C_LA    = 8'h61;
  localparam char_t C_LZ    = 8'h7A;
  localparam char_t C_UA    = 8'h41;
  localparam char_t C_UZ    = 8'h5A;
  localparam char_t C_LX    = 8'h78;
  localparam char_t C_UX    = 8'h58;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = DIGIT_W'(36);
  localparam base_t BASE_BAD  = BASE_W'(1);
  localparam base_t BASE_MAX  = BASE_W'(36);
  localparam base_t BASE_OCT  = BASE_W'(8);
  localparam base_t BASE_DEC  = BASE_W'(10);
  localparam base_t BASE_HEX  = BASE_W'(16);
  localparam pos_t  POS_LIMIT = POS_W'(MAX_LEN);

  // Map a character to its digit value, NO_DIGIT when it is not alphanumeric.
  function automatic logic [DIGIT_W-1:0] digit_of(input char_t c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= C_ZERO && c <= C_NINE)  d = DIGIT_W'(c - C_ZERO);
    else if (c >= C_LA && c <= C_LZ) d = DIGIT_W'(c - C_LA) + DIGIT_W'(10);
    else if (c >= C_UA && c <= C_UZ) d = DIGIT_W'(c - C_UA) + DIGIT_W'(10);
    return d;
  endfunction

  function automatic pos_t advance(input pos_t p);
    return (p < POS_LIMIT) ? p + POS_W'(1) : POS_LIMIT;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register: always ready; the user must write it only while idle (not enforced here).
  // ---------------------------------------------------------------------
  base_t number_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      number_base <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Input register: hold one character beat for the parse step.
  // ---------------------------------------------------------------------
  logic  stage_valid;
  char_t stage_ch;
  logic  stage_start;
  logic  step_fire;

  assign s_axis_tready = !stage_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stage_ch    <= s_axis_tdata;
      stage_start <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------
  // Parse state and the single combinational step
  // ---------------------------------------------------------------------
  logic [2:0] phase, phase_next;
  acc_t       accumulator, accumulator_next;
  logic       minus_seen, minus_seen_next;
  base_t      working_base, working_base_next;
  pos_t       position, position_next;

  logic       step_result;
  acc_t       res_mag;
  pos_t       res_pos;

  always_comb begin
    logic [DIGIT_W-1:0] d;
    logic               blank;
    logic               sign;
    logic               take_signed;

    phase_next        = phase;
    accumulator_next  = accumulator;
    minus_seen_next   = minus_seen;
    working_base_next = working_base;
    position_next     = position;
    step_result       = 1'b0;
    res_mag           = '0;
    res_pos           = '0;
    d                 = NO_DIGIT;

    // A start beat abandons whatever was in flight.
    if (stage_start) begin
      phase_next       = PH_BLANK;
      accumulator_next = '0;
      minus_seen_next  = 1'b0;
      position_next    = '0;
      if (number_base == BASE_BAD || number_base > BASE_MAX) working_base_next = BASE_BAD;
      else working_base_next = number_base;
    end

    blank = (stage_ch == C_SPACE) || (stage_ch >= C_TAB && stage_ch <= C_CR);
    sign  = (stage_ch == C_PLUS) || (stage_ch == C_MINUS);
    take_signed = (phase_next == PH_SIGNED) ||
                  (phase_next == PH_BLANK && !blank && !sign);

    if (phase_next == PH_BLANK && (blank || sign)) begin
      position_next = advance(position_next);
      if (sign) begin
        minus_seen_next = (stage_ch == C_MINUS);
        phase_next      = PH_SIGNED;
      end
    end else if (take_signed) begin
      if (stage_ch == C_ZERO &&
          (working_base_next == '0 || working_base_next == BASE_HEX)) begin
        accumulator_next = '0;
        phase_next       = PH_ZERO;
        position_next    = advance(position_next);
      end else begin
        if (working_base_next == '0) working_base_next = BASE_DEC;
        d = digit_of(stage_ch);
        if (working_base_next >= BASE_W'(2) && BASE_W'(d) < working_base_next) begin
          accumulator_next = VALUE_W'(d);
          phase_next       = PH_DIGITS;
          position_next    = advance(position_next);
        end else begin
          // Nothing consumed: report zero at the start of the string.
          minus_seen_next = 1'b0;
          step_result     = 1'b1;
          phase_next      = PH_DONE;
        end
      end
    end else begin
      case (phase_next)
        PH_ZERO: begin
          if (stage_ch == C_LX || stage_ch == C_UX) begin
            working_base_next = BASE_HEX;
            phase_next        = PH_PREFIX;
          end else begin
            if (working_base_next == '0) working_base_next = BASE_OCT;
            phase_next = PH_DIGITS;
          end
        end
        PH_PREFIX: begin
          d = digit_of(stage_ch);
          if (working_base_next >= BASE_W'(2) && BASE_W'(d) < working_base_next) begin
            accumulator_next = VALUE_W'(d);
            phase_next       = PH_DIGITS;
            // count both the 'x' and this digit
            position_next    = advance(advance(position_next));
          end else begin
            // only the leading zero counts as consumed
            step_result = 1'b1;
            res_pos     = position_next;
            phase_next  = PH_DONE;
          end
        end
        default: ;
      endcase

      // Digit accumulation, also reached from the zero phase without a prefix.
      if (phase_next == PH_DIGITS && !(phase == PH_PREFIX && !stage_start) &&
          !(phase_next == PH_DIGITS && phase == PH_ZERO && !stage_start &&
            (stage_ch == C_LX || stage_ch == C_UX))) begin
        d = digit_of(stage_ch);
        if (working_base_next >= BASE_W'(2) && BASE_W'(d) < working_base_next) begin
          accumulator_next = VALUE_W'(accumulator_next * VALUE_W'(working_base_next))
                             + VALUE_W'(d);
          position_next    = advance(position_next);
        end else begin
          step_result = 1'b1;
          res_mag     = accumulator_next;
          res_pos     = position_next;
          phase_next  = PH_DONE;
        end
      end
    end
  end

  // Fire the step whenever a beat is held, unless its result has nowhere to go.
  assign step_fire = stage_valid && (!step_result || !m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      accumulator  <= '0;
      minus_seen   <= 1'b0;
      working_base <= BASE_DEC;
      position     <= '0;
    end else if (step_fire) begin
      phase        <= phase_next;
      accumulator  <= accumulator_next;
      minus_seen   <= minus_seen_next;
      working_base <= working_base_next;
      position     <= position_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: negate, wrap, sign-extend and pack.
  // ---------------------------------------------------------------------
  acc_t                  res_wrapped;
  logic [OUT_VAL_W-1:0]  res_value;

  assign res_wrapped = minus_seen_next ? (VALUE_W'(0) - res_mag) : res_mag;
  assign res_value   = OUT_VAL_W'(signed'(res_wrapped));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step_fire && step_result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step_result) begin
      m_axis_tdata <= OUT_TDATA_W'({OFFSET_W'(res_pos), res_value});
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_result |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a beat not yet taken");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_result |=> phase == PH_DONE)
    else $error("phase not done after a result");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> stage_valid && step_result)
    else $error("input stalled with nothing pending");

  a_position_bounded: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> position <= POS_LIMIT)
    else $error("offset passed its saturation point");

endmodule

// ----- tb/ascii_integer_parser_checker.sv -----
// Result checker for the ASCII integer parser: mirrors the conversion state
// from the accepted character beats and compares every result beat.
// Depends on aip_pkg for widths, limits and types.
`timescale 1ns / 1ps

module ascii_integer_parser_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  aip_pkg::base_t      cfg_data,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  aip_pkg::char_t      s_axis_tdata,   // [7:0] ch
  input  logic                s_axis_tuser,   // [0] start_req
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  aip_pkg::out_tdata_t m_axis_tdata,   // [31:0] value, [43:32] end_offset, rest 0
  output int                  fault_count,
  output int                  awaiting
);
  import aip_pkg::*;

  localparam base_t BASE_AUTO = 6'd0;
  localparam base_t BASE_BAD  = 6'd1;
  localparam base_t BASE_MIN  = 6'd2;
  localparam base_t BASE_OCT  = 6'd8;
  localparam base_t BASE_DEC  = 6'd10;
  localparam base_t BASE_HEX  = 6'd16;
  localparam base_t BASE_TOP  = 6'd36;
  localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd36;
  localparam char_t BLANK_LO  = 8'd9;
  localparam char_t BLANK_HI  = 8'd13;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_BLANK, SCAN_SIGN, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS, SCAN_DONE
  } scan_t;

  typedef struct packed {
    acc_t                value;
    logic [OFFSET_W-1:0] offset;
  } number_t;

  number_t pending_numbers[$];
  base_t   base_reg;
  base_t   radix;
  scan_t   scan;
  acc_t    acc;
  logic    neg;
  pos_t    pos;
  int      faults;

  function automatic logic [DIGIT_W-1:0] digit_of_char(input char_t c);
    if (c >= "0" && c <= "9") return DIGIT_W'(c - "0");
    if (c >= "a" && c <= "z") return DIGIT_W'(c - "a" + 8'd10);
    if (c >= "A" && c <= "Z") return DIGIT_W'(c - "A" + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic bit in_radix(input logic [DIGIT_W-1:0] d);
    return radix >= BASE_MIN && d < radix;
  endfunction

  function automatic void bump_pos();
    if (pos < pos_t'(MAX_LEN)) pos = pos + 1'b1;
  endfunction

  function automatic bit conclude(input acc_t mag, input pos_t off, output number_t res);
    res.value  = neg ? acc_t'(-mag) : mag;
    res.offset = OFFSET_W'(off);
    scan = SCAN_DONE;
    return 1'b1;
  endfunction

  function automatic bit take_digit(input logic [DIGIT_W-1:0] d, output number_t res);
    res = '0;
    if (in_radix(d)) begin
      acc = acc_t'(acc * radix + d);
      bump_pos();
      return 1'b0;
    end
    return conclude(acc, pos, res);
  endfunction

  // Advance the conversion by one character; returns 1 when it ends here.
  function automatic bit parse_char(input char_t c, input logic first, output number_t res);
    logic [DIGIT_W-1:0] d;
    res = '0;
    d = digit_of_char(c);
    if (first) begin
      scan  = SCAN_BLANK;
      acc   = '0;
      neg   = 1'b0;
      pos   = '0;
      radix = (base_reg == BASE_BAD || base_reg > BASE_TOP) ? BASE_BAD : base_reg;
    end
    case (scan)
      SCAN_BLANK, SCAN_SIGN: begin
        if (scan == SCAN_BLANK) begin
          if (c == " " || (c >= BLANK_LO && c <= BLANK_HI)) begin
            bump_pos();
            return 1'b0;
          end
          if (c == "-" || c == "+") begin
            neg = (c == "-");
            bump_pos();
            scan = SCAN_SIGN;
            return 1'b0;
          end
        end
        if (c == "0" && (radix == BASE_AUTO || radix == BASE_HEX)) begin
          acc  = '0;
          scan = SCAN_ZERO;
          bump_pos();
          return 1'b0;
        end
        if (radix == BASE_AUTO) radix = BASE_DEC;
        if (in_radix(d)) begin
          acc  = acc_t'(d);
          scan = SCAN_DIGITS;
          bump_pos();
          return 1'b0;
        end
        // nothing taken: report the start of the string
        neg = 1'b0;
        return conclude('0, '0, res);
      end
      SCAN_ZERO: begin
        if (c == "x" || c == "X") begin
          radix = BASE_HEX;
          scan  = SCAN_PREFIX;
          return 1'b0;
        end
        if (radix == BASE_AUTO) radix = BASE_OCT;
        scan = SCAN_DIGITS;
        return take_digit(d, res);
      end
      SCAN_PREFIX: begin
        if (in_radix(d)) begin
          acc  = acc_t'(d);
          scan = SCAN_DIGITS;
          bump_pos();
          bump_pos();
          return 1'b0;
        end
        // bare prefix: only the zero counts as consumed
        return conclude('0, pos, res);
      end
      SCAN_DIGITS: return take_digit(d, res);
      default:     return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    faults++;
  endtask

  initial faults = 0;

  always @(posedge clk) begin : watch
    number_t want;
    number_t got;
    if (rst) begin
      base_reg = BASE_RESET;
      radix    = BASE_DEC;
      scan     = SCAN_IDLE;
      acc      = '0;
      neg      = 1'b0;
      pos      = '0;
      pending_numbers.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_numbers.size() == 0) begin
          report_mismatch("result beat with no conversion pending",
                          m_axis_tdata[OUT_VAL_W-1:0], '0);
        end else begin
          want = pending_numbers.pop_front();
          got.value  = m_axis_tdata[OUT_VAL_W-1:0];
          got.offset = m_axis_tdata[OUT_VAL_W +: OFFSET_W];
          if (got.value !== want.value)
            report_mismatch("value", got.value, want.value);
          if (got.offset !== want.offset)
            report_mismatch("end_offset", 32'(got.offset), 32'(want.offset));
          if (m_axis_tdata[OUT_TDATA_W-1:OUT_RAW_W] !== '0)
            report_mismatch("tdata padding", 32'(m_axis_tdata[OUT_TDATA_W-1:OUT_RAW_W]), '0);
        end
      end
      if (cfg_valid && cfg_ready) base_reg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_char(s_axis_tdata, s_axis_tuser, want)) pending_numbers.push_back(want);
      end
    end
    awaiting    <= pending_numbers.size();
    fault_count <= faults;
  end

endmodule

// ----- tb/ascii_integer_parser_tb.sv -----
// Top of the ASCII integer parser testbench: clock, reset, character and
// base stimulus, result back-pressure and the verdict; checking is done by
// ascii_integer_parser_checker. Depends on aip_pkg, the parser RTL and the checker.
`timescale 1ns / 1ps

module ascii_integer_parser_tb;
  import aip_pkg::*;

  localparam int    HALF_PERIOD  = 10;
  localparam int    IDLE_PCT     = 6;        // idle cycles per hundred on each side
  localparam int    DRAIN_CYCLES = 6;        // covers the input and result registers plus margin
  localparam int    CYCLE_LIMIT  = 300000;
  localparam int    RANDOM_CHARS = 1400;
  localparam char_t NUL          = 8'h00;
  localparam char_t BLANK_LO     = 8'd9;
  localparam base_t BASE_AUTO    = 6'd0;
  localparam base_t BASE_BAD     = 6'd1;
  localparam base_t BASE_MIN     = 6'd2;
  localparam base_t BASE_OCT     = 6'd8;
  localparam base_t BASE_DEC     = 6'd10;
  localparam base_t BASE_HEX     = 6'd16;
  localparam base_t BASE_TOP     = 6'd36;
  localparam base_t BASE_MAX     = 6'd63;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  base_t      cfg_data      = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  char_t      s_axis_tdata  = '0;    // [7:0] ch
  logic       s_axis_tuser  = 1'b0;  // [0] start_req
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  out_tdata_t m_axis_tdata;          // [31:0] value, [43:32] end_offset, rest 0

  int  fault_count;
  int  awaiting;
  int  cycle_count;
  int  conversion_chars = 0;
  bit  steady  = 1'b0;   // set: neither side idles
  bit  opening = 1'b0;   // set: the next fed character opens a string

  ascii_integer_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ascii_integer_parser_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fault_count   (fault_count),
    .awaiting      (awaiting)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Result side: drop tready at random, IDLE_PCT percent of the time, independent of
  // what the block is doing, so stalls land on every phase of a conversion.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: end the run as failed if it has not finished by CYCLE_LIMIT.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one character beat and hold it until accepted. Random idle cycles
  // go in front of the beat; tvalid is left high after acceptance so that
  // back-to-back beats need no second assignment in one step.
  task automatic send_char(input char_t c, input logic first);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic open);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], open && i == 0);
  endtask

  // Feed a character of a generated string; the first one carries the start.
  task automatic feed(input char_t c);
    send_char(c, opening);
    opening = 1'b0;
    conversion_chars++;
  endtask

  // Stop sending and hold off until every expected result has been seen,
  // then give the pipeline time to swallow characters that produce nothing.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Base changes only go in while the block is quiet.
  task automatic write_base(input base_t b);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One generated number: optional blanks, sign and prefix, digits valid for the
  // base (decimal when it is out of range), then a terminator that is NUL, a random
  // byte, or nothing at all (the string is left open for the next start to abandon).
  task automatic send_number(input base_t b);
    int radix;
    int digits;
    int r;
    int v;
    radix = (b == BASE_AUTO || b < BASE_MIN || b > BASE_TOP) ? int'(BASE_DEC) : int'(b);
    opening = 1'b1;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 5);
      feed(r == 0 ? char_t'(" ") : char_t'(BLANK_LO + r - 1));
    end
    r = $urandom_range(0, 3);
    if (r == 0) feed("-");
    else if (r == 1) feed("+");
    if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 1)) begin
      feed("0");
      r = $urandom_range(0, 2);
      if (r < 2) begin
        feed(r == 0 ? char_t'("x") : char_t'("X"));
        radix = BASE_HEX;
      end else if (b == BASE_AUTO) begin
        radix = BASE_OCT;
      end
    end
    if ($urandom_range(0, 11) == 0) digits = 0;
    else if ($urandom_range(0, 7) == 0) digits = $urandom_range(10, 14);
    else digits = $urandom_range(1, 6);
    repeat (digits) begin
      v = $urandom_range(0, radix - 1);
      if (v < 10) feed(char_t'("0" + v));
      else feed(char_t'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
    end
    r = $urandom_range(0, 7);
    if (r < 3) feed(NUL);
    else if (r < 7) feed(char_t'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int    phase_no;
    int    stop_at;
    base_t b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset base first, no register write yet.
    send_text(" -7", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("9", 1'b1);
    send_char(NUL, 1'b0);
    send_text("Z", 1'b0);           // stray character after a result: ignored
    send_text("12", 1'b1);          // abandoned by the next start
    send_text("+3", 1'b1);
    send_char(NUL, 1'b0);
    send_text("\t-;", 1'b1);        // sign with no digits

    write_base(BASE_HEX);
    send_text("0xg", 1'b1);         // bare prefix
    send_text("0XfF", 1'b1);
    send_char(NUL, 1'b0);

    write_base(BASE_AUTO);
    send_text("017", 1'b1);
    send_char(NUL, 1'b0);
    send_text("08", 1'b1);
    send_char(NUL, 1'b0);
    send_text("-5", 1'b1);
    send_char(NUL, 1'b0);

    write_base(BASE_TOP);
    send_text("zZ", 1'b1);
    send_char(NUL, 1'b0);
    write_base(BASE_BAD);
    send_text("1", 1'b1);
    send_char(NUL, 1'b0);
    write_base(BASE_MAX);
    send_text("5", 1'b1);
    send_char(NUL, 1'b0);
    write_base(BASE_MIN);
    send_text("1012", 1'b1);

    // Random: one base per phase, drain between phases. Phases three and
    // four run with no idling on either side.
    phase_no = 0;
    while (conversion_chars < RANDOM_CHARS) begin
      case ($urandom_range(0, 9))
        0:       b = BASE_AUTO;
        1:       b = BASE_HEX;
        2:       b = BASE_DEC;
        3:       b = BASE_OCT;
        4:       b = BASE_MIN;
        5:       b = BASE_TOP;
        6:       b = $urandom_range(0, 1) ? BASE_BAD : base_t'($urandom_range(37, 63));
        default: b = base_t'($urandom_range(2, 36));
      endcase
      write_base(b);
      steady  = (phase_no == 3 || phase_no == 4);
      stop_at = conversion_chars + $urandom_range(60, 160);
      while (conversion_chars < stop_at) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: random bytes, now and then with a start
          repeat ($urandom_range(1, 5))
            send_char(char_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
          send_number(b);
        end
      end
      steady = 1'b0;
      phase_no++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
